// ----- src/mm_pkg.sv -----
// shared types, constants and codes of the matrix multiplier
package mm_pkg;

    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int IDX_W       = 6;
    localparam int KIND_W      = 2;
    localparam int DEF_MAX_DIM = 8;
    localparam int PROD_W      = 2 * VALUE_BITS;
    localparam int ACC_W       = PROD_W + CFG_W;

    localparam logic [KIND_W-1:0] KIND_WRITE_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C_COLS = 3'd5;

    typedef struct packed {
        logic [CFG_W-1:0] a_rows;
        logic [CFG_W-1:0] a_cols;
        logic [CFG_W-1:0] b_rows;
        logic [CFG_W-1:0] b_cols;
        logic [CFG_W-1:0] c_rows;
        logic [CFG_W-1:0] c_cols;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0]            kind;
        logic [IDX_W-1:0]             elem_index;
        logic signed [VALUE_BITS-1:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] out_value;
        logic [IDX_W-1:0]             out_index;
        logic                         last;
        logic                         shape_error;
    } out_item_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic lastk;
    } mac_op_t;

    typedef struct packed {
        logic             load;
        logic             shape_error;
        logic             last;
        logic [IDX_W-1:0] index;
    } out_load_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_ISSUE,
        ST_DRAIN,
        ST_ERR
    } state_t;

endpackage

// ----- src/mm_store.sv -----
// single-port-write, registered-read element store
module mm_store import mm_pkg::*; #(
    parameter int DEPTH = DEF_MAX_DIM * DEF_MAX_DIM,
    parameter int AW    = 6
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [AW-1:0]                waddr,
    input  logic signed [VALUE_BITS-1:0] wdata,
    input  logic [AW-1:0]                raddr,
    output logic signed [VALUE_BITS-1:0] rdata
);

    logic signed [VALUE_BITS-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ----- src/mm_mac.sv -----
// shared multiply-accumulate unit with scaling and saturation
module mm_mac import mm_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mac_op_t                      op,
    input  logic signed [VALUE_BITS-1:0] a_data,
    input  logic signed [VALUE_BITS-1:0] b_data,
    output logic                         done,
    output logic signed [VALUE_BITS-1:0] value
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (VALUE_BITS - 1) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;

    mac_op_t                  op_d_reg;
    mac_op_t                  op_p_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic signed [ACC_W-1:0]  shifted;

    // op is delayed to line up with the registered store read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_d_reg <= '0;
            op_p_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            op_d_reg <= op;
            op_p_reg <= op_d_reg;
            done_reg <= op_p_reg.vld && op_p_reg.lastk;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= a_data * b_data;
        if (op_p_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_next = (op_p_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);

    // floor shift, then clamp to the value range
    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb begin
        if (shifted > SAT_MAX) begin
            value = $signed(SAT_MAX[VALUE_BITS-1:0]);
        end else if (shifted < SAT_MIN) begin
            value = $signed(SAT_MIN[VALUE_BITS-1:0]);
        end else begin
            value = $signed(shifted[VALUE_BITS-1:0]);
        end
    end

    assign done = done_reg;

endmodule

// ----- src/mm_ctrl.sv -----
// sequencer: shape check, store addressing and result ordering
module mm_ctrl import mm_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM,
    parameter int AW      = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cfg_t          cfg,
    input  logic          s_valid,
    input  in_item_t      s_item,
    output logic          s_ready,
    input  logic          out_free,
    input  logic          mac_done,
    output mac_op_t       mac_op,
    output logic [AW-1:0] a_raddr,
    output logic [AW-1:0] b_raddr,
    output out_load_t     out_ld
);

    state_t           state_reg, state_next;
    logic [CFG_W-1:0] i_reg, i_next;
    logic [CFG_W-1:0] j_reg, j_next;
    logic [CFG_W-1:0] k_reg, k_next;
    logic [AW-1:0]    a_base_reg, a_base_next;
    logic [AW-1:0]    a_ptr_reg, a_ptr_next;
    logic [AW-1:0]    b_ptr_reg, b_ptr_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    logic             shape_ok;
    logic             last_k;
    logic             last_elem;
    logic             start_acc;

    function automatic logic dim_ok(input logic [CFG_W-1:0] d);
        return (d != '0) && (32'(d) <= MAX_DIM);
    endfunction

    assign shape_ok = dim_ok(cfg.a_rows) && dim_ok(cfg.a_cols) && dim_ok(cfg.b_rows) &&
                      dim_ok(cfg.b_cols) && dim_ok(cfg.c_rows) && dim_ok(cfg.c_cols) &&
                      (cfg.a_cols == cfg.b_rows) && (cfg.a_rows == cfg.c_rows) &&
                      (cfg.b_cols == cfg.c_cols);

    assign last_k    = (k_reg == cfg.a_cols - CFG_W'(1));
    assign last_elem = (i_reg == cfg.a_rows - CFG_W'(1)) && (j_reg == cfg.b_cols - CFG_W'(1));
    assign s_ready   = (state_reg == ST_IDLE);
    assign start_acc = s_valid && s_ready && (s_item.kind == KIND_START);
    assign a_raddr   = a_ptr_reg;
    assign b_raddr   = b_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        a_base_reg <= a_base_next;
        a_ptr_reg  <= a_ptr_next;
        b_ptr_reg  <= b_ptr_next;
        oidx_reg   <= oidx_next;
    end

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_base_next = a_base_reg;
        a_ptr_next  = a_ptr_reg;
        b_ptr_next  = b_ptr_reg;
        oidx_next   = oidx_reg;
        mac_op      = '0;
        out_ld      = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start_acc) begin
                    i_next      = '0;
                    j_next      = '0;
                    a_base_next = '0;
                    oidx_next   = '0;
                    state_next  = shape_ok ? ST_WAIT : ST_ERR;
                end
            end
            ST_WAIT: begin
                // the output slot is empty by the time this element lands
                if (out_free) begin
                    a_ptr_next = a_base_reg;
                    b_ptr_next = AW'(j_reg);
                    k_next     = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                mac_op.vld   = 1'b1;
                mac_op.first = (k_reg == '0);
                mac_op.lastk = last_k;
                k_next       = k_reg + CFG_W'(1);
                a_ptr_next   = a_ptr_reg + AW'(1);
                b_ptr_next   = b_ptr_reg + AW'(cfg.b_cols);
                if (last_k) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (mac_done) begin
                    out_ld.load  = 1'b1;
                    out_ld.last  = last_elem;
                    out_ld.index = oidx_reg;
                    if (last_elem) begin
                        state_next = ST_IDLE;
                    end else begin
                        oidx_next = oidx_reg + IDX_W'(1);
                        if (j_reg == cfg.b_cols - CFG_W'(1)) begin
                            j_next      = '0;
                            i_next      = i_reg + CFG_W'(1);
                            a_base_next = a_base_reg + AW'(cfg.a_cols);
                        end else begin
                            j_next = j_reg + CFG_W'(1);
                        end
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    out_ld.load        = 1'b1;
                    out_ld.shape_error = 1'b1;
                    out_ld.last        = 1'b1;
                    out_ld.index       = '0;
                    state_next         = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_ld.load |-> out_free)
        else $error("result loaded while output register still full");

    a_no_mac_result_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mac_done)
        else $error("mac result arrived with sequencer idle");

    a_bad_shape_goes_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (start_acc && !shape_ok) |=> (state_reg == ST_ERR))
        else $error("shape mismatch did not lead to error result");

    a_issue_only_in_issue: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_op.vld |-> (state_reg == ST_ISSUE) && !out_ld.load)
        else $error("mac issue outside issue phase");
`endif

endmodule

// ----- src/matrix_multiply.sv -----
// a write transaction is taken whenever s_ready is high; a start gives its results one
// element at a time, each set by the single shared mac fed from the two store read ports,
// one product a cycle; a bad shape gives a single error result instead.
// one start is worked on at a time; s_ready is low from start until the last result loads.
// reset (aresetn, synchronous, active low) sets all shape registers to 1 and clears control;
// the element stores are not cleared.
module matrix_multiply import mm_pkg::*; #(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (AW > IDX_W) ? AW : IDX_W;

    cfg_t                         cfg_reg, cfg_next;
    logic                         m_valid_reg;
    out_item_t                    m_item_reg;
    logic                         out_free;
    logic [IW-1:0]                idx_ext;
    logic [AW-1:0]                waddr;
    logic                         wr_ok;
    logic                         a_we, b_we;
    logic [AW-1:0]                a_raddr, b_raddr;
    logic signed [VALUE_BITS-1:0] a_rdata, b_rdata;
    mac_op_t                      mac_op;
    logic                         mac_done;
    logic signed [VALUE_BITS-1:0] mac_value;
    out_load_t                    out_ld;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_A_ROWS: cfg_next.a_rows = cfg_wdata;
                REG_A_COLS: cfg_next.a_cols = cfg_wdata;
                REG_B_ROWS: cfg_next.b_rows = cfg_wdata;
                REG_B_COLS: cfg_next.b_cols = cfg_wdata;
                REG_C_ROWS: cfg_next.c_rows = cfg_wdata;
                REG_C_COLS: cfg_next.c_cols = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{a_rows: CFG_W'(1), a_cols: CFG_W'(1), b_rows: CFG_W'(1),
                         b_cols: CFG_W'(1), c_rows: CFG_W'(1), c_cols: CFG_W'(1)};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // element writes beyond the store depth are dropped
    assign idx_ext = IW'(s_item.elem_index);
    assign waddr   = idx_ext[AW-1:0];
    assign wr_ok   = s_valid && s_ready && (32'(s_item.elem_index) < DEPTH);
    assign a_we    = wr_ok && (s_item.kind == KIND_WRITE_A);
    assign b_we    = wr_ok && (s_item.kind == KIND_WRITE_B);

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_a (
        .aclk  (aclk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (s_item.elem_value),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    mm_store #(.DEPTH(DEPTH), .AW(AW)) u_store_b (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (s_item.elem_value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    mm_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (mac_op),
        .a_data  (a_rdata),
        .b_data  (b_rdata),
        .done    (mac_done),
        .value   (mac_value)
    );

    mm_ctrl #(.MAX_DIM(MAX_DIM), .AW(AW)) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_item   (s_item),
        .s_ready  (s_ready),
        .out_free (out_free),
        .mac_done (mac_done),
        .mac_op   (mac_op),
        .a_raddr  (a_raddr),
        .b_raddr  (b_raddr),
        .out_ld   (out_ld)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ld.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ld.load) begin
            m_item_reg.out_value   <= out_ld.shape_error ? '0 : mac_value;
            m_item_reg.out_index   <= out_ld.index;
            m_item_reg.last        <= out_ld.last;
            m_item_reg.shape_error <= out_ld.shape_error;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule
